/* rtl/core/query_key_signed_value_parser_top_macros.svh */
// Assertion macros used by the port-level checker.
`ifndef QUERY_KEY_SIGNED_VALUE_PARSER_TOP_MACROS_SVH
`define QUERY_KEY_SIGNED_VALUE_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define QKSV_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qksv assertion failed");

// Next-cycle implication, disabled while reset is low.
`define QKSV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qksv assertion failed");

`endif

/* rtl/core/qksv_pkg.sv */
// Package: types, constants and helpers for the query key value parser.
`timescale 1ns / 1ps

package qksv_pkg;

    localparam int MAX_DIGITS = 4;
    localparam int DigW       = $clog2(MAX_DIGITS + 1);
    localparam int MagW       = 14;
    localparam int AccW       = MagW + 4;
    localparam int ValW       = MagW + 1;
    localparam int KeyLen     = 11;
    localparam int KeyPosW    = 4;

    localparam logic [MagW-1:0] MagSat = {MagW{1'b1}};

    localparam logic [7:0] ChAmp   = 8'h26;
    localparam logic [7:0] ChMinus = 8'h2d;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;

    typedef enum logic [2:0] {
        PH_MATCH      = 3'd0,
        PH_SKIP       = 3'd1,
        PH_AFTER_KEY  = 3'd2,
        PH_AFTER_SIGN = 3'd3,
        PH_DIGITS     = 3'd4,
        PH_DECIDED    = 3'd5
    } t_phase;

    // Characters of the key, by position.
    function automatic logic [7:0] key_char(input logic [KeyPosW-1:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = 8'h66; // f
            4'd1:    c = 8'h61; // a
            4'd2:    c = 8'h75; // u
            4'd3:    c = 8'h6c; // l
            4'd4:    c = 8'h74; // t
            4'd5:    c = 8'h5f; // _
            4'd6:    c = 8'h73; // s
            4'd7:    c = 8'h6c; // l
            4'd8:    c = 8'h61; // a
            4'd9:    c = 8'h62; // b
            4'd10:   c = 8'h3d; // =
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/query_key_signed_value_parser_top.sv */
// Top level: byte-serial parser for a signed keyed value in a query string.
//
//   channel   dir  handshake                  payload
//   s_axis    in   i_s_axis_tvalid/o_tready   tdata[7:0] query_byte, tlast final_byte
//   m_axis    out  o_m_axis_tvalid/i_tready   tdata[0] declined, [15:1] fault_value
//   cfg       in   i_cfg_we                   i_cfg_wdata hook_ready
//
// One byte per cycle while o_s_axis_tready is high; the parse state advances at the
// request edge, and a final byte's result is registered in the same edge.
// A two-entry output (result register plus skid register) lets input run on while
// a result waits; o_s_axis_tready drops only when both entries are full.
// Synchronous active-low reset clears parse state, hook_ready and both entries.
`timescale 1ns / 1ps

module query_key_signed_value_parser_top
    import qksv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] query_byte
    input  logic        i_s_axis_tlast,   // final_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [0] declined, [15:1] fault_value
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata       // hook_ready
);

    t_phase              r_phase,     n_phase;
    logic [KeyPosW-1:0]  r_key_pos,   n_key_pos;
    logic                r_sign,      n_sign;
    logic [DigW-1:0]     r_dig_cnt,   n_dig_cnt;
    logic [MagW-1:0]     r_mag,       n_mag;
    logic                r_decline,   n_decline;
    logic                r_hook_ready;

    logic                r_out_valid;
    logic [15:0]         r_out_data;
    logic                r_skid_valid;
    logic [15:0]         r_skid_data;

    logic                s_req;
    logic                m_req;
    logic [7:0]          in_byte;
    logic                is_digit;
    logic [AccW-1:0]     acc;
    logic [MagW-1:0]     mag_next;
    logic                take_digit;
    logic                res_ok;
    logic [ValW-1:0]     res_mag;
    logic [ValW-1:0]     res_val;
    logic [15:0]         res_data;

    assign o_s_axis_tready = ~r_skid_valid;
    assign s_req           = i_s_axis_tvalid & o_s_axis_tready;
    assign m_req           = r_out_valid & i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign in_byte  = i_s_axis_tdata;
    assign is_digit = (in_byte >= ChZero) && (in_byte <= ChNine);

    // Saturating accumulate; magnitude never decreases, so saturating early matches
    // saturating at the output.
    assign acc      = {{(AccW-MagW){1'b0}}, r_mag} * AccW'(10)
                      + {{(AccW-4){1'b0}}, in_byte[3:0]};
    assign mag_next = (acc > {{(AccW-MagW){1'b0}}, MagSat}) ? MagSat : acc[MagW-1:0];

    always_comb begin
        n_phase    = r_phase;
        n_key_pos  = r_key_pos;
        n_sign     = r_sign;
        n_dig_cnt  = r_dig_cnt;
        n_mag      = r_mag;
        n_decline  = r_decline;
        take_digit = 1'b0;

        unique case (r_phase)
            PH_MATCH: begin
                if (in_byte == key_char(r_key_pos)) begin
                    n_key_pos = r_key_pos + KeyPosW'(1);
                    if (r_key_pos == KeyPosW'(KeyLen - 1)) begin
                        n_phase = PH_AFTER_KEY;
                    end
                end else begin
                    n_key_pos = '0;
                    n_phase   = (in_byte == ChAmp) ? PH_MATCH : PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (in_byte == ChAmp) begin
                    n_phase   = PH_MATCH;
                    n_key_pos = '0;
                end
            end
            PH_AFTER_KEY: begin
                priority if (in_byte == ChMinus) begin
                    n_sign  = 1'b1;
                    n_phase = PH_AFTER_SIGN;
                end else if (is_digit) begin
                    take_digit = 1'b1;
                    n_phase    = PH_DIGITS;
                end else begin
                    n_phase   = PH_DECIDED;
                    n_decline = 1'b1;
                end
            end
            PH_AFTER_SIGN: begin
                if (is_digit) begin
                    take_digit = 1'b1;
                    n_phase    = PH_DIGITS;
                end else begin
                    n_phase   = PH_DECIDED;
                    n_decline = 1'b1;
                end
            end
            PH_DIGITS: begin
                priority if (is_digit) begin
                    if (r_dig_cnt >= DigW'(MAX_DIGITS)) begin
                        n_phase   = PH_DECIDED;
                        n_decline = 1'b1;
                    end else begin
                        take_digit = 1'b1;
                    end
                end else if (in_byte == ChAmp) begin
                    n_phase   = PH_DECIDED;
                    n_decline = 1'b0;
                end else begin
                    n_phase   = PH_DECIDED;
                    n_decline = 1'b1;
                end
            end
            default: begin
                // decided: rest of the query is ignored
            end
        endcase

        if (take_digit) begin
            n_dig_cnt = r_dig_cnt + DigW'(1);
            n_mag     = mag_next;
        end

        res_ok  = r_hook_ready &&
                  ((n_phase == PH_DIGITS) || ((n_phase == PH_DECIDED) && !n_decline));
        res_mag = {1'b0, n_mag};
        res_val = n_sign ? (ValW'(0) - res_mag) : res_mag;
        res_data = res_ok ? {res_val, 1'b0} : 16'h0001;

        // final byte returns the parser to its start state
        if (i_s_axis_tlast) begin
            n_phase   = PH_MATCH;
            n_key_pos = '0;
            n_sign    = 1'b0;
            n_dig_cnt = '0;
            n_mag     = '0;
            n_decline = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_MATCH;
            r_key_pos    <= '0;
            r_sign       <= 1'b0;
            r_dig_cnt    <= '0;
            r_mag        <= '0;
            r_decline    <= 1'b0;
            r_hook_ready <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_hook_ready <= i_cfg_wdata;
            end
            if (s_req) begin
                r_phase   <= n_phase;
                r_key_pos <= n_key_pos;
                r_sign    <= n_sign;
                r_dig_cnt <= n_dig_cnt;
                r_mag     <= n_mag;
                r_decline <= n_decline;
            end
        end
    end

    // Result register with skid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (s_req && i_s_axis_tlast) begin
                if (!r_out_valid || m_req) begin
                    r_out_valid <= 1'b1;
                    r_out_data  <= res_data;
                end else begin
                    r_skid_valid <= 1'b1;
                    r_skid_data  <= res_data;
                end
            end else if (m_req) begin
                r_out_valid  <= r_skid_valid;
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end
        end
    end

endmodule

/* rtl/core/qksv_checker.sv */
// Port-level checker for the query key value parser, bound to the top level.
`timescale 1ns / 1ps
`include "query_key_signed_value_parser_top_macros.svh"

module qksv_checker
    import qksv_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        i_s_axis_tlast,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata
);

    logic s_req_final;
    logic m_stall;
    logic m_decline;

    assign s_req_final = i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast;
    assign m_stall     = o_m_axis_tvalid && !i_m_axis_tready;
    assign m_decline   = o_m_axis_tvalid && o_m_axis_tdata[0];

    // a stalled result holds
    `QKSV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_stall, o_m_axis_tvalid && $stable(o_m_axis_tdata))
    // a decline carries a zero value
    `QKSV_ASSERT_SAME(a_decline_zero, i_clk, i_rst_n, m_decline, o_m_axis_tdata[15:1] == 15'd0)
    // after a final byte is taken, the output is always valid in the next cycle
    `QKSV_ASSERT_NEXT(a_final_result, i_clk, i_rst_n, s_req_final, o_m_axis_tvalid)
    // non-final bytes never create a result
    `QKSV_ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, !o_m_axis_tvalid && !s_req_final, !o_m_axis_tvalid)

endmodule

bind query_key_signed_value_parser_top qksv_checker u_qksv_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

/* tb/fault_value_checker.sv */
// Checker: predicts each parser result from the accepted query bytes and compares it.
`timescale 1ns / 1ps

module fault_value_checker
    import qksv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_values,
    output int          o_declines
);

    typedef struct packed {
        logic                   declined;
        logic signed [ValW-1:0] value;
    } t_fault_result;

    // key text, first character in the top byte
    localparam logic [8*KeyLen-1:0] KEY_TEXT = 88'h66_61_75_6c_74_5f_73_6c_61_62_3d;

    // shadow parse state
    t_phase      phase;
    int          key_pos;
    logic        sign_seen;
    int          digits;
    logic [31:0] mag;
    logic        decline_decided;
    logic        hook_ready;

    t_fault_result expected_results[$];
    t_fault_result want;
    t_fault_result got;
    int            fails;
    int            values;
    int            declines;

    initial begin
        fails    = 0;
        values   = 0;
        declines = 0;
    end

    function automatic logic is_dec(input logic [7:0] b);
        return (b >= ChZero) && (b <= ChNine);
    endfunction

    task automatic clear_parse();
        phase           = PH_MATCH;
        key_pos         = 0;
        sign_seen       = 1'b0;
        digits          = 0;
        mag             = '0;
        decline_decided = 1'b0;
    endtask

    task automatic add_digit(input logic [7:0] b);
        digits++;
        mag = mag * 10 + (b - ChZero);
    endtask

    task automatic advance_parse(input logic [7:0] b);
        case (phase)
            PH_MATCH: begin
                if (key_pos < KeyLen && b == KEY_TEXT[8*(KeyLen-1-key_pos) +: 8]) begin
                    key_pos++;
                    if (key_pos == KeyLen) begin
                        phase = PH_AFTER_KEY;
                    end
                end else begin
                    key_pos = 0;
                    phase   = (b == ChAmp) ? PH_MATCH : PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (b == ChAmp) begin
                    phase   = PH_MATCH;
                    key_pos = 0;
                end
            end
            PH_AFTER_KEY: begin
                if (b == ChMinus) begin
                    sign_seen = 1'b1;
                    phase     = PH_AFTER_SIGN;
                end else if (is_dec(b)) begin
                    add_digit(b);
                    phase = PH_DIGITS;
                end else begin
                    phase           = PH_DECIDED;
                    decline_decided = 1'b1;
                end
            end
            PH_AFTER_SIGN: begin
                if (is_dec(b)) begin
                    add_digit(b);
                    phase = PH_DIGITS;
                end else begin
                    phase           = PH_DECIDED;
                    decline_decided = 1'b1;
                end
            end
            PH_DIGITS: begin
                if (is_dec(b) && digits < MAX_DIGITS) begin
                    add_digit(b);
                end else begin
                    // '&' closes a good value; extra digit or junk declines
                    phase           = PH_DECIDED;
                    decline_decided = (b != ChAmp);
                end
            end
            default: ;
        endcase
    endtask

    function automatic t_fault_result query_result();
        t_fault_result   r;
        logic            ok;
        logic [MagW-1:0] m;
        ok         = (phase == PH_DIGITS) || (phase == PH_DECIDED && !decline_decided);
        r.declined = 1'b1;
        r.value    = '0;
        if (ok && hook_ready) begin
            m          = (mag > MagSat) ? MagSat : mag[MagW-1:0];
            r.declined = 1'b0;
            r.value    = sign_seen ? -$signed({1'b0, m}) : $signed({1'b0, m});
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            hook_ready = 1'b0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                hook_ready = i_cfg_wdata;
            end
            if (i_s_tvalid && i_s_tready) begin
                advance_parse(i_s_tdata);
                if (i_s_tlast) begin
                    expected_results.push_back(query_result());
                    clear_parse();
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got.declined = i_m_tdata[0];
                got.value    = i_m_tdata[15:1];
                if (expected_results.size() == 0) begin
                    fails++;
                    $display("%0t: result with nothing expected: declined %0d value %0d",
                             $time, got.declined, $signed(got.value));
                end else begin
                    want = expected_results.pop_front();
                    if (want.declined) begin
                        declines++;
                    end else begin
                        values++;
                    end
                    if (got.declined !== want.declined) begin
                        fails++;
                        $display("%0t: declined mismatch, expected %0d actual %0d",
                                 $time, want.declined, got.declined);
                    end
                    if (got.value !== want.value) begin
                        fails++;
                        $display("%0t: fault_value mismatch, expected %0d actual %0d",
                                 $time, $signed(want.value), $signed(got.value));
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
        o_values     <= values;
        o_declines   <= declines;
    end

endmodule

/* tb/tb_top.sv */
// Testbench top: query byte stimulus, output stalls, config writes and the verdict.
`timescale 1ns / 1ps

module tb_top;
    import qksv_pkg::*;

    localparam int RANDOM_BYTES = 1000;
    localparam int LIMIT_CYCLES = 100000;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = '0;
    logic        i_s_axis_tlast  = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;
    logic        i_cfg_we        = 1'b0;
    logic        i_cfg_wdata     = 1'b0;

    int chk_fails;
    int chk_pending;
    int chk_values;
    int chk_declines;

    int   cycle_count = 0;
    int   byte_total  = 0;
    int   hold_cycles = 0;
    bit   gaps_on     = 1'b1;
    bit   stalls_on   = 1'b1;
    logic [7:0] query_buf[$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    query_key_signed_value_parser_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    fault_value_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tlast    (i_s_axis_tlast),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (chk_fails),
        .o_pending    (chk_pending),
        .o_values     (chk_values),
        .o_declines   (chk_declines)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, chk_pending);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // result side: per-result stall, plus a long hold-off on request
    initial begin
        int stall;
        int hold;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_cycles > 0) begin
                hold        = hold_cycles;
                hold_cycles = 0;
                i_m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            stall = stalls_on ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    function automatic logic is_dec(input logic [7:0] b);
        return (b >= ChZero) && (b <= ChNine);
    endfunction

    task automatic push_byte(input logic [7:0] b);
        query_buf.push_back(b);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            query_buf.push_back(s[i]);
        end
    endtask

    // first n characters of the key
    task automatic push_key(input int n);
        for (int k = 0; k < n; k++) begin
            push_byte(key_char(KeyPosW'(k)));
        end
    endtask

    task automatic push_digits(input int n);
        repeat (n) push_byte(ChZero + 8'($urandom_range(0, 9)));
    endtask

    // bytes biased toward the key's own characters to provoke partial matches
    task automatic push_noise(input int n);
        string alphabet;
        alphabet = "fault_sb=&-09xz";
        repeat (n) push_byte(alphabet[$urandom_range(0, alphabet.len() - 1)]);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        byte_total++;
    endtask

    task automatic send_query();
        for (int i = 0; i < query_buf.size(); i++) begin
            send_byte(query_buf[i], i == query_buf.size() - 1);
        end
        query_buf.delete();
    endtask

    task automatic send_text(input string s);
        push_text(s);
        send_query();
    endtask

    // query made of head text, the full key, then tail text
    task automatic send_keyed(input string head, input string tail);
        push_text(head);
        push_key(KeyLen);
        push_text(tail);
        send_query();
    endtask

    // stop sending and let every expected result arrive
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_hook(input logic ready);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= ready;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic build_random_query();
        int         kind;
        logic [7:0] b;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3, 4: begin
                // well-formed, possibly after other parameters and before more
                repeat ($urandom_range(0, 2)) begin
                    push_noise($urandom_range(0, 5));
                    push_byte(ChAmp);
                end
                push_key(KeyLen);
                if ($urandom_range(0, 1)) push_byte(ChMinus);
                push_digits($urandom_range(1, MAX_DIGITS));
                if ($urandom_range(0, 1)) begin
                    push_byte(ChAmp);
                    push_noise($urandom_range(0, 6));
                end
            end
            5: begin
                push_key(KeyLen);
                if ($urandom_range(0, 1)) push_byte(ChMinus);
                push_digits(MAX_DIGITS + $urandom_range(1, 2));
            end
            6: begin
                push_key(KeyLen);
                push_digits($urandom_range(1, MAX_DIGITS));
                do b = 8'($urandom_range(0, 255)); while (b == ChAmp || is_dec(b));
                push_byte(b);
                push_noise($urandom_range(0, 3));
            end
            7: begin
                case ($urandom_range(0, 4))
                    0: begin
                        do b = 8'($urandom_range(0, 255)); while (b == ChAmp);
                        push_byte(b);
                        push_key(KeyLen);
                        push_digits($urandom_range(1, MAX_DIGITS));
                    end
                    1: begin
                        push_key($urandom_range(1, KeyLen - 1));
                        if ($urandom_range(0, 1)) push_digits(2);
                    end
                    2: begin
                        push_key(KeyLen);
                        if ($urandom_range(0, 1)) push_byte(ChMinus);
                    end
                    3: begin
                        push_key(KeyLen);
                        do b = 8'($urandom_range(0, 255)); while (b == ChMinus || is_dec(b));
                        push_byte(b);
                        push_noise($urandom_range(0, 3));
                    end
                    default: begin
                        push_key(KeyLen);
                        push_byte(ChMinus);
                        do b = 8'($urandom_range(0, 255)); while (is_dec(b));
                        push_byte(b);
                        push_noise($urandom_range(0, 3));
                    end
                endcase
            end
            8: begin
                repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
            end
            default: begin
                // leading zeros or negative zero, then a second key that must not matter
                push_key(KeyLen);
                if ($urandom_range(0, 1)) push_byte(ChMinus);
                push_byte(ChZero);
                push_digits($urandom_range(0, MAX_DIGITS - 1));
                push_byte(ChAmp);
                push_key(KeyLen);
                push_noise($urandom_range(1, 3));
            end
        endcase
    endtask

    initial begin
        int query_n;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // hook still at its reset value: a good value must be declined
        send_keyed("", "12");
        set_hook(1'b1);

        send_keyed("", "9999");
        send_keyed("", "-9999");
        send_keyed("", "0");
        send_keyed("", "-0");
        send_keyed("a=1&", "-42&b=x");
        send_keyed("x", "5");
        push_text("x");
        push_key(KeyLen);
        push_text("5&");
        push_key(KeyLen);
        push_text("7");
        send_query();
        push_key(KeyLen - 2);
        send_query();
        send_keyed("", "");
        send_keyed("", "-");
        send_keyed("", "x1");
        send_keyed("", "-a");
        send_keyed("", "12345");
        send_keyed("", "12a");
        send_text("q=v");
        send_keyed("&", "3");
        push_key(KeyLen);
        push_text("5&");
        push_key(KeyLen);
        push_text("x");
        send_query();
        push_byte(8'h00);
        send_query();
        push_byte(8'hff);
        send_query();

        set_hook(1'b0);
        send_keyed("", "77");
        send_keyed("", "-5&z");
        set_hook(1'b1);

        byte_total = 0;
        query_n    = 0;
        while (byte_total < RANDOM_BYTES) begin
            if (query_n == 20) begin
                // output held off while one-byte queries keep coming: fills the skid
                gaps_on     = 1'b0;
                hold_cycles = 300;
                repeat (30) begin
                    push_byte(8'($urandom_range(0, 255)));
                    send_query();
                end
            end
            if (query_n == 40) set_hook(1'b0);
            if (query_n == 45) set_hook(1'b1);
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            build_random_query();
            send_query();
            query_n++;
        end

        drain();
        repeat (10) @(posedge i_clk);

        $display("summary: %0d random queries plus directed cases, hook on and off",
                 query_n);
        $display("summary: %0d results checked, %0d values and %0d declines",
                 chk_values + chk_declines, chk_values, chk_declines);
        if (chk_fails == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
